/* hw/rtl/matrix_multiply_defines.svh */
// Assertion macros shared by the matrix multiplier RTL.
`ifndef MATRIX_MULTIPLY_DEFINES_SVH
`define MATRIX_MULTIPLY_DEFINES_SVH

// Property must hold on every clock edge outside reset.
`define MM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/mm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiplier package
// Shared sizes, register indices, types and the dimension and scaling functions.
// ----------------------------------------------------------------------------
package mm_pkg;
  localparam int MaxDim    = 8;
  localparam int FracBits  = 16;
  localparam int DimW      = $clog2(MaxDim + 1);
  localparam int IdxW      = $clog2(MaxDim);
  localparam int AddrW     = $clog2(MaxDim * MaxDim);
  localparam int CntW      = $clog2(2 * MaxDim * MaxDim + 1);
  localparam int ProdW     = 64;
  localparam int AccW      = ProdW + $clog2(MaxDim) + 1;

  localparam logic [1:0] RegRowsA  = 2'd0;
  localparam logic [1:0] RegInner  = 2'd1;
  localparam logic [1:0] RegColsB  = 2'd2;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN
  } state_e;

  // Control handed along the cell chain together with each operand pair.
  typedef struct packed {
    logic first;
    logic last_term;
    logic last_elem;
  } tag_t;

  function automatic logic [DimW-1:0] eff_dim(input logic [3:0] v);
    logic [DimW-1:0] r;
    if (v == 4'd0) r = DimW'(1);
    else if (32'(v) > MaxDim) r = DimW'(MaxDim);
    else r = DimW'(v);
    return r;
  endfunction

  function automatic logic [31:0] scale_sat(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0] s;
    logic [31:0] r;
    s = acc >>> FracBits;
    if (s > AccW'(signed'(32'sh7fffffff))) r = 32'h7fffffff;
    else if (s < -AccW'(64'sh80000000)) r = 32'h80000000;
    else r = s[31:0];
    return r;
  endfunction
endpackage

/* hw/rtl/mm_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Stream interfaces
// Valid/ready channels for elements, products and register writes.
// ----------------------------------------------------------------------------
interface mm_elem_if;
  logic        valid;
  logic        ready;
  logic [31:0] element;
  modport source (output valid, output element, input ready);
  modport sink (input valid, input element, output ready);
endinterface

interface mm_prod_if;
  logic        valid;
  logic        ready;
  logic [31:0] product_element;
  logic        last_of_product;
  modport source (output valid, output product_element, output last_of_product,
                  input ready);
  modport sink (input valid, input product_element, input last_of_product,
                output ready);
endinterface

interface mm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [3:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/mm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mm_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* hw/rtl/mm_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Matrix multiplier cell
// One stage of the MAC chain; each cell registers its operands, product and sum.
// ----------------------------------------------------------------------------
module mm_cell (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  mm_pkg::tag_t                       tag_i,
  input  logic signed [31:0]                 a_i,
  input  logic signed [31:0]                 b_i,
  input  logic signed [mm_pkg::ProdW-1:0]    prod_i,
  input  logic signed [mm_pkg::AccW-1:0]     acc_i,
  output logic                               valid_o,
  output mm_pkg::tag_t                       tag_o,
  output logic signed [31:0]                 a_o,
  output logic signed [31:0]                 b_o,
  output logic signed [mm_pkg::ProdW-1:0]    prod_o,
  output logic signed [mm_pkg::AccW-1:0]     acc_o
);
  // A cell with the multiply role feeds prod_o; a cell with the accumulate
  // role folds prod_i into acc_i. Both roles are present in every cell and
  // the neighbors pick what they use.
  logic               valid_q;
  mm_pkg::tag_t       tag_q;
  logic signed [31:0] a_q, b_q;
  logic signed [mm_pkg::ProdW-1:0] prod_q;
  logic signed [mm_pkg::AccW-1:0]  acc_q;
  logic signed [mm_pkg::AccW-1:0]  acc_d;

  always_comb begin
    acc_d = (tag_i.first ? '0 : acc_i) + mm_pkg::AccW'(prod_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q  <= tag_i;
    a_q    <= a_i;
    b_q    <= b_i;
    prod_q <= a_i * b_i;
    if (valid_i) acc_q <= acc_d;
  end

  assign valid_o = valid_q;
  assign tag_o   = tag_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign prod_o  = prod_q;
  assign acc_o   = acc_q;
endmodule

/* hw/rtl/matrix_multiply.sv */
`timescale 1ns / 1ps
// After the beat completing B the block enters the run state and issues the terms
// of each product element; they pass the RAM read, multiply cell, accumulate cell
// and output register, and the next dot product starts once the previous beat is
// taken. Input ready returns after the last product beat is taken, when the drain
// state sees the pipeline empty and moves back to the load state. Reset clears
// control and the load count and sets all dimensions to 8; the RAMs are not cleared.
// ----------------------------------------------------------------------------
// Matrix multiplier
// Loads A and B into RAMs and runs a short chain of MAC cells over them.
// ----------------------------------------------------------------------------
`include "matrix_multiply_defines.svh"

module matrix_multiply (
  input  logic clk_i,
  input  logic rst_ni,
  mm_cfg_if.sink    cfg,
  mm_elem_if.sink   in_ch,
  mm_prod_if.source out_ch
);
  logic [3:0] rows_q, inner_q, cols_q;
  logic [mm_pkg::DimW-1:0] m, k, n;
  logic [mm_pkg::CntW-1:0] load_q, a_len, total;
  mm_pkg::state_e state_q, state_d;
  logic [mm_pkg::DimW-1:0] i_q, j_q, t_q;
  logic [mm_pkg::AddrW:0] a_base_q;
  logic issue, in_acc, cfg_acc, last_load;
  logic a_we, b_we;
  logic [mm_pkg::AddrW-1:0] a_waddr, b_waddr, a_raddr, b_raddr;
  logic [31:0] a_rdata, b_rdata;
  logic rd_valid_q;
  mm_pkg::tag_t rd_tag_q, issue_tag;
  // Cell chain wiring: cell 0 multiplies, cell 1 accumulates.
  logic c0_valid, c1_valid;
  mm_pkg::tag_t c0_tag, c1_tag;
  logic signed [31:0] c0_a, c0_b, c1_a, c1_b;
  logic signed [mm_pkg::ProdW-1:0] c0_prod, c1_prod;
  logic signed [mm_pkg::AccW-1:0] c0_acc, c1_acc;
  logic out_valid_q, pend_q;
  logic [31:0] out_data_q;
  logic out_last_q;
  logic inflight_q;
  logic done_issue;
  logic unused;

  assign m = mm_pkg::eff_dim(rows_q);
  assign k = mm_pkg::eff_dim(inner_q);
  assign n = mm_pkg::eff_dim(cols_q);
  assign a_len = mm_pkg::CntW'(m) * mm_pkg::CntW'(k);
  assign total = a_len + mm_pkg::CntW'(k) * mm_pkg::CntW'(n);

  assign cfg.ready = 1'b1;
  assign cfg_acc   = cfg.valid;
  assign in_ch.ready = (state_q == mm_pkg::ST_LOAD);
  assign in_acc    = in_ch.valid && in_ch.ready;
  assign last_load = in_acc && (load_q + 1'b1 == total);

  assign a_we    = in_acc && (load_q < a_len);
  assign b_we    = in_acc && !(load_q < a_len);
  assign a_waddr = load_q[mm_pkg::AddrW-1:0];
  assign b_waddr = mm_pkg::AddrW'(load_q - a_len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= 4'd8;
      inner_q <= 4'd8;
      cols_q  <= 4'd8;
    end else if (cfg_acc) begin
      unique case (cfg.index)
        mm_pkg::RegRowsA: rows_q  <= cfg.data;
        mm_pkg::RegInner: inner_q <= cfg.data;
        mm_pkg::RegColsB: cols_q  <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q <= '0;
    end else if (cfg_acc && (cfg.index == mm_pkg::RegRowsA ||
                             cfg.index == mm_pkg::RegInner ||
                             cfg.index == mm_pkg::RegColsB)) begin
      load_q <= '0;
    end else if (in_acc) begin
      load_q <= last_load ? '0 : load_q + 1'b1;
    end
  end

  // In the run state, issue one term per cycle; a new dot product starts only once the output slot is free.
  assign issue = (state_q == mm_pkg::ST_RUN) &&
                 !(t_q == '0 && inflight_q != '0);
  assign done_issue = issue && t_q == k - 1'b1 && j_q == n - 1'b1 &&
                      i_q == m - 1'b1;
  assign a_raddr = mm_pkg::AddrW'(a_base_q + mm_pkg::AddrW'(t_q));
  assign b_raddr = mm_pkg::AddrW'(t_q) * mm_pkg::AddrW'(n) + mm_pkg::AddrW'(j_q);
  assign issue_tag.first     = (t_q == '0);
  assign issue_tag.last_term = (t_q == k - 1'b1);
  assign issue_tag.last_elem = (j_q == n - 1'b1) && (i_q == m - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mm_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mm_pkg::ST_LOAD:  if (last_load) state_d = mm_pkg::ST_RUN;
      mm_pkg::ST_RUN:   if (done_issue) state_d = mm_pkg::ST_DRAIN;
      mm_pkg::ST_DRAIN: if (inflight_q == '0 && !rd_valid_q && !c0_valid && !c1_valid &&
                            !pend_q) state_d = mm_pkg::ST_LOAD;
      default:  state_d = mm_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
      t_q <= '0;
      a_base_q <= '0;
    end else if (state_q == mm_pkg::ST_LOAD) begin
      i_q <= '0;
      j_q <= '0;
      t_q <= '0;
      a_base_q <= '0;
    end else if (issue) begin
      if (t_q != k - 1'b1) begin
        t_q <= t_q + 1'b1;
      end else begin
        t_q <= '0;
        if (j_q != n - 1'b1) begin
          j_q <= j_q + 1'b1;
        end else begin
          j_q <= '0;
          i_q <= i_q + 1'b1;
          a_base_q <= a_base_q + (mm_pkg::AddrW + 1)'(k);
        end
      end
    end
  end

  mm_ram #(.Width(32), .Depth(mm_pkg::MaxDim * mm_pkg::MaxDim)) u_a_ram (
    .clk_i, .we_i(a_we), .waddr_i(a_waddr), .wdata_i(in_ch.element),
    .raddr_i(a_raddr), .rdata_o(a_rdata)
  );
  mm_ram #(.Width(32), .Depth(mm_pkg::MaxDim * mm_pkg::MaxDim)) u_b_ram (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(in_ch.element),
    .raddr_i(b_raddr), .rdata_o(b_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= issue;
    end
  end
  always_ff @(posedge clk_i) rd_tag_q <= issue_tag;

  mm_cell u_cell0 (
    .clk_i, .rst_ni, .valid_i(rd_valid_q), .tag_i(rd_tag_q),
    .a_i(a_rdata), .b_i(b_rdata), .prod_i('0), .acc_i('0),
    .valid_o(c0_valid), .tag_o(c0_tag), .a_o(c0_a), .b_o(c0_b),
    .prod_o(c0_prod), .acc_o(c0_acc)
  );
  mm_cell u_cell1 (
    .clk_i, .rst_ni, .valid_i(c0_valid), .tag_i(c0_tag),
    .a_i(c0_a), .b_i(c0_b), .prod_i(c0_prod), .acc_i(c1_acc),
    .valid_o(c1_valid), .tag_o(c1_tag), .a_o(c1_a), .b_o(c1_b),
    .prod_o(c1_prod), .acc_o(c1_acc)
  );
  assign unused = ^{c0_acc, c1_a, c1_b, c1_prod};

  // A dot product occupies the output slot from its first issued term until
  // its beat is taken, so at most one result waits at a time.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
      out_valid_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      if (issue && t_q == '0) inflight_q <= 1'b1;
      else if (out_valid_q && out_ch.ready) inflight_q <= '0;
      if (c1_valid && c1_tag.last_term) out_valid_q <= 1'b1;
      else if (out_ch.ready) out_valid_q <= 1'b0;
      pend_q <= (c1_valid && c1_tag.last_term) || (out_valid_q && !out_ch.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (c1_valid && c1_tag.last_term) begin
      out_data_q <= mm_pkg::scale_sat(c1_acc);
      out_last_q <= c1_tag.last_elem;
    end
  end

  assign out_ch.valid = out_valid_q;
  assign out_ch.product_element = out_data_q;
  assign out_ch.last_of_product = out_last_q;

  `MM_ASSERT(a_no_load_in_run, !(in_acc && state_q != mm_pkg::ST_LOAD), "input taken while busy")
  `MM_ASSERT(a_one_result, !(c1_valid && c1_tag.last_term && out_valid_q && !out_ch.ready),
             "result overwrites a waiting beat")
  `MM_ASSERT_NEXT(a_last_to_run, last_load, state_q == mm_pkg::ST_RUN, "no run after load")
endmodule
